FILE: hw/rtl/sctl_pkg.sv
package sctl_pkg;

    localparam int NUM_SLAVES = 4;
    localparam int IDX_W      = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;
    localparam int ADDR_W     = 3;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_WRITE_ID   = 2'd1;
    localparam logic [1:0] OP_WRITE_DATA = 2'd2;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_LOST_SLAVE   = 2'd1;
    localparam logic [1:0] ERR_TX_NOT_READY = 2'd2;

    localparam logic [0:0] REG_RESET_INTERVAL = 1'b0;

    localparam logic [15:0] ATTEMPTS_MAX = 16'hFFFF;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] slave;
        logic [7:0] value;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_command_bit;
        logic       tx_ready;
    } in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_command_bit;
        logic       ack_valid;
        logic [1:0] ack_slave;
        logic [7:0] ack_data;
        logic       slave_fault;
        logic [1:0] error_code;
        logic       reset_request;
    } out_t;

endpackage

FILE: hw/rtl/sctl_apb.sv
module sctl_apb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sctl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [15:0]                reset_interval
);

    localparam int ADDR_W_TOP = sctl_pkg::ADDR_W - 1;

    logic [15:0] reset_interval_reg;
    logic        wr_en;
    logic        sel_interval;

    // low two address bits are the byte offset within a word
    assign sel_interval = (paddr[ADDR_W_TOP:2] == sctl_pkg::REG_RESET_INTERVAL);
    assign wr_en        = psel && penable && pwrite && pready;
    assign pready       = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_interval_reg <= 16'd0;
        end
        else if (wr_en && sel_interval)
        begin
            reset_interval_reg <= pwdata[15:0];
        end
    end

    assign prdata         = sel_interval ? {16'd0, reset_interval_reg} : 32'd0;
    assign reset_interval = reset_interval_reg;

endmodule

FILE: hw/rtl/sctl_core.sv
module sctl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  sctl_pkg::in_t       item,
    input  logic [15:0]         reset_interval,
    output sctl_pkg::out_t      result
);

    localparam int N = sctl_pkg::NUM_SLAVES;
    localparam int W = sctl_pkg::IDX_W;

    sctl_pkg::idx_t current_slave_reg;
    logic           byte_phase_reg;
    logic           first_ack_pending_reg;
    logic [7:0]     slave_id_reg   [N];
    logic [7:0]     tick_data_reg  [N];
    logic [15:0]    attempts_reg   [N];

    sctl_pkg::idx_t current_slave_next;
    logic [W:0]     prev_inc;
    logic           phase_next;
    sctl_pkg::idx_t id_addr;
    logic [7:0]     id_rd;
    logic [7:0]     data_rd;
    logic [15:0]    att_rd;
    logic [15:0]    att_inc;
    logic           ok;
    logic           is_tick;
    logic           wr_in_range;
    sctl_pkg::idx_t wr_idx;

    assign is_tick     = (item.op == sctl_pkg::OP_TICK);
    assign wr_in_range = (32'(item.slave) < 32'(N));
    assign wr_idx      = W'(item.slave);

    assign phase_next = ~byte_phase_reg;
    assign prev_inc   = {1'b0, current_slave_reg} + {{W{1'b0}}, 1'b1};

    always_comb
    begin
        current_slave_next = current_slave_reg;
        if (byte_phase_reg)
        begin
            current_slave_next = (32'(prev_inc) >= 32'(N)) ? '0 : prev_inc[W-1:0];
        end
    end

    // ID table: the reply check needs the previous slave only in the ID-reply
    // phase, the transmitter needs the current one only in the ID-send phase
    assign id_addr = phase_next ? current_slave_reg : current_slave_next;
    assign id_rd   = slave_id_reg[id_addr];
    assign data_rd = tick_data_reg[current_slave_next];
    assign att_rd  = attempts_reg[current_slave_reg];
    assign att_inc = (att_rd == sctl_pkg::ATTEMPTS_MAX) ? att_rd : att_rd + 16'd1;

    always_comb
    begin
        if (first_ack_pending_reg)
        begin
            ok = 1'b1;
        end
        else if (!item.rx_valid)
        begin
            ok = 1'b0;
        end
        else if (phase_next)
        begin
            ok = item.rx_command_bit && (item.rx_byte == id_rd);
        end
        else
        begin
            ok = 1'b1;
        end
    end

    always_comb
    begin
        result = '0;
        if (is_tick)
        begin
            if (!first_ack_pending_reg && item.rx_valid && !phase_next)
            begin
                result.ack_valid = 1'b1;
                result.ack_slave = 2'(current_slave_reg);
                result.ack_data  = item.rx_byte;
            end
            if (!ok)
            begin
                result.slave_fault   = 1'b1;
                result.error_code    = sctl_pkg::ERR_LOST_SLAVE;
                result.reset_request = (att_inc >= reset_interval);
            end
            if (!item.tx_ready)
            begin
                result.error_code = sctl_pkg::ERR_TX_NOT_READY;
            end
            else
            begin
                result.tx_valid       = 1'b1;
                result.tx_command_bit = ~phase_next;
                result.tx_byte        = phase_next ? data_rd : id_rd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_slave_reg     <= '0;
            byte_phase_reg        <= 1'b1;
            first_ack_pending_reg <= 1'b1;
            for (int i = 0; i < N; i++)
            begin
                slave_id_reg[i]  <= 8'd0;
                tick_data_reg[i] <= 8'd0;
                attempts_reg[i]  <= 16'd0;
            end
        end
        else if (item_valid)
        begin
            case (item.op)
                sctl_pkg::OP_TICK:
                begin
                    current_slave_reg     <= current_slave_next;
                    byte_phase_reg        <= phase_next;
                    first_ack_pending_reg <= 1'b0;
                    attempts_reg[current_slave_reg] <= ok ? 16'd0 : att_inc;
                end
                sctl_pkg::OP_WRITE_ID:
                begin
                    if (wr_in_range)
                    begin
                        slave_id_reg[wr_idx] <= item.value;
                    end
                end
                sctl_pkg::OP_WRITE_DATA:
                begin
                    if (wr_in_range)
                    begin
                        tick_data_reg[wr_idx] <= item.value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/shared_clock_master_tick_link.sv
// Channel  Direction  Handshake           Payload
// in       to block   in_valid/in_stall   in_data   (sctl_pkg::in_t)
// out      from block out_valid/out_stall out_data  (sctl_pkg::out_t)
// cfg      to block   APB psel/penable    paddr, pwdata, prdata
//
// One transaction per cycle sustained while out is not stalled; an item accepted
// into the input register passes through the tick logic into the result register.
// Reset (rst_n, async, active low) sets the phase and first-reply flag and clears
// the slave index, tables and attempt counters at once; no clearing pass is needed.
// A stall on out holds the result register and backs up through the input
// register to in_stall in the same cycle.
module shared_clock_master_tick_link (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sctl_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sctl_pkg::out_t              out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sctl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic           in_valid_reg;
    sctl_pkg::in_t  in_data_reg;
    logic           out_valid_reg;
    sctl_pkg::out_t out_data_reg;
    logic           advance;
    logic [15:0]    reset_interval;
    sctl_pkg::out_t result;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    sctl_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .reset_interval (reset_interval)
    );

    sctl_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (in_valid_reg && advance),
        .item           (in_data_reg),
        .reset_interval (reset_interval),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.tx_valid
                        && out_data.error_code == sctl_pkg::ERR_TX_NOT_READY))
        else $error("byte sent while transmitter flagged not ready");

    a_ack_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ack_valid |-> !out_data.slave_fault)
        else $error("acknowledge data given with a lost-slave error");

    a_req_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reset_request |-> out_data.slave_fault)
        else $error("network reset requested without a failed reply");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with no blocked item inside");

endmodule

FILE: verif/tick_link_checker.sv
module tick_link_checker
    import sctl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  in_t               in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_t              out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] RESET_INTERVAL_ADDR = ADDR_W'(4 * REG_RESET_INTERVAL);

    // shadow of the link engine
    logic [15:0] interval_shadow;
    idx_t        poll_slave;
    logic        phase_shadow;
    logic        first_reply;
    logic [7:0]  id_shadow [NUM_SLAVES];
    logic [7:0]  data_shadow [NUM_SLAVES];
    logic [15:0] miss_count [NUM_SLAVES];

    out_t        due_frames [$];
    int          mismatches;

    assign fail_count = mismatches;

    function automatic out_t advance_link(input in_t it);
        out_t r;
        idx_t prev;
        logic ok;
        r = '0;
        case (it.op)
            OP_WRITE_ID:
            begin
                if (int'(it.slave) < NUM_SLAVES)
                    id_shadow[it.slave] = it.value;
            end
            OP_WRITE_DATA:
            begin
                if (int'(it.slave) < NUM_SLAVES)
                    data_shadow[it.slave] = it.value;
            end
            OP_TICK:
            begin
                prev = poll_slave;
                if (!phase_shadow)
                    phase_shadow = 1'b1;
                else
                begin
                    phase_shadow = 1'b0;
                    poll_slave = (int'(prev) + 1 >= NUM_SLAVES) ? '0 : idx_t'(prev + 1'b1);
                end

                // reply belongs to the byte sent on the previous tick
                if (first_reply)
                begin
                    first_reply = 1'b0;
                    ok = 1'b1;
                end
                else if (!it.rx_valid)
                    ok = 1'b0;
                else if (phase_shadow)
                    ok = it.rx_command_bit && (it.rx_byte == id_shadow[prev]);
                else
                begin
                    r.ack_valid = 1'b1;
                    r.ack_slave = prev;
                    r.ack_data  = it.rx_byte;
                    ok = 1'b1;
                end

                if (!ok)
                begin
                    r.slave_fault = 1'b1;
                    r.error_code  = ERR_LOST_SLAVE;
                    if (miss_count[prev] != ATTEMPTS_MAX)
                        miss_count[prev] = miss_count[prev] + 16'd1;
                    if (miss_count[prev] >= interval_shadow)
                        r.reset_request = 1'b1;
                end
                else
                    miss_count[prev] = '0;

                // busy transmitter overrides the lost-slave code
                if (!it.tx_ready)
                    r.error_code = ERR_TX_NOT_READY;
                else
                begin
                    r.tx_valid = 1'b1;
                    if (!phase_shadow)
                    begin
                        r.tx_command_bit = 1'b1;
                        r.tx_byte        = id_shadow[poll_slave];
                    end
                    else
                        r.tx_byte = data_shadow[poll_slave];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            interval_shadow = '0;
            poll_slave      = '0;
            phase_shadow    = 1'b1;
            first_reply     = 1'b1;
            for (int i = 0; i < NUM_SLAVES; i++)
            begin
                id_shadow[i]   = '0;
                data_shadow[i] = '0;
                miss_count[i]  = '0;
            end
            due_frames.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == RESET_INTERVAL_ADDR)
                interval_shadow = pwdata[15:0];

            if (out_valid && !out_stall)
            begin
                if (due_frames.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = due_frames.pop_front();
                    check_field("tx_valid", want.tx_valid, out_data.tx_valid);
                    check_field("tx_byte", want.tx_byte, out_data.tx_byte);
                    check_field("tx_command_bit", want.tx_command_bit, out_data.tx_command_bit);
                    check_field("ack_valid", want.ack_valid, out_data.ack_valid);
                    check_field("ack_slave", want.ack_slave, out_data.ack_slave);
                    check_field("ack_data", want.ack_data, out_data.ack_data);
                    check_field("slave_fault", want.slave_fault, out_data.slave_fault);
                    check_field("error_code", want.error_code, out_data.error_code);
                    check_field("reset_request", want.reset_request, out_data.reset_request);
                end
            end

            if (in_valid && !in_stall)
                due_frames.push_back(advance_link(in_data));

            outstanding <= due_frames.size();
        end
    end

endmodule

FILE: verif/shared_clock_master_tick_link_tb.sv
module shared_clock_master_tick_link_tb;
    import sctl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] RESET_INTERVAL_ADDR = ADDR_W'(4 * REG_RESET_INTERVAL);
    localparam logic [1:0]        OP_UNUSED           = 2'd3;
    localparam int                IDLE_LIMIT          = 1000;
    localparam int                SETTLE_CYCLES       = 4;
    localparam int                IN_W                = $bits(in_t);

    typedef enum int {RX_GOOD, RX_MISSING, RX_NO_CMD, RX_WRONG_ID, RX_NOISE} reply_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_t               in_data;
    logic              out_valid;
    logic              out_stall;
    out_t              out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                outstanding;

    int                gap_pct;
    int                stall_pct;
    int                stall_left;
    int                idle_run;

    // stimulus-side mirror, used to build replies from the expected slave IDs
    logic              gen_phase;
    idx_t              gen_slave;
    logic [7:0]        gen_ids [NUM_SLAVES];

    int                n_ticks;
    int                n_writes;
    int                n_unused;
    int                n_busy;
    int                n_settings;

    shared_clock_master_tick_link u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tick_link_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // receiver back-pressure in bursts of random length
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        idle_run = 0;
        while (idle_run < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input in_t it);
        logic held;
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_tick(input reply_t kind, input logic txr);
        in_t  it;
        idx_t prev;
        prev = gen_slave;
        if (gen_phase)
        begin
            gen_phase = 1'b0;
            gen_slave = (int'(prev) + 1 >= NUM_SLAVES) ? '0 : idx_t'(prev + 1'b1);
        end
        else
            gen_phase = 1'b1;

        it                = in_t'(IN_W'($urandom));
        it.op             = OP_TICK;
        it.tx_ready       = txr;
        case (kind)
            RX_GOOD:
            begin
                it.rx_valid = 1'b1;
                if (gen_phase)
                begin
                    it.rx_command_bit = 1'b1;
                    it.rx_byte        = gen_ids[prev];
                end
            end
            RX_MISSING:
                it.rx_valid = 1'b0;
            RX_NO_CMD:
            begin
                it.rx_valid       = 1'b1;
                it.rx_command_bit = 1'b0;
                it.rx_byte        = gen_ids[prev];
            end
            RX_WRONG_ID:
            begin
                it.rx_valid       = 1'b1;
                it.rx_command_bit = 1'b1;
                it.rx_byte        = gen_ids[prev] ^ (8'h01 << $urandom_range(7));
            end
            default:
            begin
            end
        endcase
        n_ticks++;
        if (!txr)
            n_busy++;
        send_item(it);
    endtask

    task automatic send_write(input logic [1:0] op, input idx_t slv, input logic [7:0] val);
        in_t it;
        it       = in_t'(IN_W'($urandom));
        it.op    = op;
        it.slave = slv;
        it.value = val;
        if (op == OP_WRITE_ID)
            gen_ids[slv] = val;
        if (op == OP_UNUSED)
            n_unused++;
        else
            n_writes++;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_interval(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RESET_INTERVAL_ADDR;
        pwdata  <= {16'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
        @(posedge clk);
    endtask

    task automatic run_random(input int count, input int pause_at);
        int     pick;
        int     rk;
        reply_t kind;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_idle();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                rk = $urandom_range(99);
                if (rk < 80)
                    kind = RX_GOOD;
                else if (rk < 86)
                    kind = RX_MISSING;
                else if (rk < 90)
                    kind = RX_NO_CMD;
                else if (rk < 95)
                    kind = RX_WRONG_ID;
                else
                    kind = RX_NOISE;
                send_tick(kind, $urandom_range(99) < 92);
            end
            else if (pick < 85)
            begin
                if ($urandom_range(3) == 0)
                    send_write(OP_WRITE_ID, idx_t'($urandom), $urandom_range(1) ? 8'h31 : 8'h32);
                else
                    send_write(OP_WRITE_ID, idx_t'($urandom), 8'($urandom));
            end
            else if (pick < 98)
                send_write(OP_WRITE_DATA, idx_t'($urandom), 8'($urandom));
            else
                send_write(OP_UNUSED, idx_t'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        gap_pct    = 0;
        stall_pct  = 0;
        gen_phase  = 1'b1;
        gen_slave  = '0;
        n_ticks    = 0;
        n_writes   = 0;
        n_unused   = 0;
        n_busy     = 0;
        n_settings = 0;
        for (int i = 0; i < NUM_SLAVES; i++)
            gen_ids[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset interval still 0, first reply is not looked at
        send_tick(RX_NOISE, 1'b1);
        send_write(OP_WRITE_ID, 2'd0, 8'h31);
        send_write(OP_WRITE_ID, 2'd1, 8'h32);
        send_write(OP_WRITE_ID, 2'd2, 8'h00);
        send_write(OP_WRITE_ID, 2'd3, 8'hFF);
        send_write(OP_WRITE_DATA, 2'd0, 8'h00);
        send_write(OP_WRITE_DATA, 2'd1, 8'hFF);
        send_write(OP_WRITE_DATA, 2'd2, 8'hA5);
        send_write(OP_WRITE_DATA, 2'd3, 8'h5A);
        send_write(OP_UNUSED, 2'd3, 8'hFF);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_MISSING, 1'b1);
        send_tick(RX_MISSING, 1'b1);
        send_tick(RX_NO_CMD, 1'b1);
        send_tick(RX_WRONG_ID, 1'b1);
        send_tick(RX_WRONG_ID, 1'b1);
        send_tick(RX_GOOD, 1'b0);
        send_tick(RX_MISSING, 1'b0);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_GOOD, 1'b1);
        send_tick(RX_NOISE, 1'b1);
        wait_idle();

        gap_pct   = 20;
        stall_pct = 20;
        set_interval(16'd1);
        run_random(225, -1);
        wait_idle();

        // sender holds off mid-phase until every result is back
        gap_pct   = 30;
        stall_pct = 10;
        set_interval(16'hFFFF);
        run_random(225, 110);
        wait_idle();

        gap_pct   = 40;
        stall_pct = 40;
        set_interval(16'd3);
        run_random(225, -1);
        wait_idle();

        gap_pct   = 5;
        stall_pct = 30;
        set_interval(16'($urandom_range(2, 6)));
        run_random(225, -1);
        wait_idle();

        gap_pct   = 0;
        stall_pct = 0;
        set_interval(16'd0);
        run_random(225, -1);
        wait_idle();

        $display("covered %0d ticks (%0d with transmitter busy), %0d table writes, %0d unused ops",
                 n_ticks, n_busy, n_writes, n_unused);
        $display("over %0d reset interval settings from 0 to 65535, with stalls and gaps",
                 n_settings);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sctl_pkg.sv
hw/rtl/sctl_apb.sv
hw/rtl/sctl_core.sv
hw/rtl/shared_clock_master_tick_link.sv
verif/tick_link_checker.sv
verif/shared_clock_master_tick_link_tb.sv
